@@ sv/rtyc_pkg.sv @@
// Shared constants, types and arithmetic helpers for the RGB to YUV 4:2:0 converter.
`default_nettype none
package rtyc_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int CfgW      = 11;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int SlotW     = ColW - 1;
    localparam int PairSlots = MaxWidth / 2;
    localparam int PixW      = 8;
    localparam int TermW     = 25;
    localparam int PairW     = TermW + 1;
    localparam int SumW      = TermW + 3;
    localparam int FracW     = 18;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [CfgW-1:0] SizeMin   = CfgW'(2);
    localparam logic [CfgW-1:0] WidthMax  = CfgW'(MaxWidth);
    localparam logic [CfgW-1:0] HeightMax = CfgW'(MaxHeight);

    localparam logic signed [TermW-1:0] CoefYR = 25'sd19589;
    localparam logic signed [TermW-1:0] CoefYG = 25'sd38443;
    localparam logic signed [TermW-1:0] CoefYB = 25'sd7497;
    localparam logic signed [TermW-1:0] CoefUB = 25'sd28613;
    localparam logic signed [TermW-1:0] CoefUG = 25'sd18953;
    localparam logic signed [TermW-1:0] CoefUR = 25'sd9657;
    localparam logic signed [TermW-1:0] CoefVR = 25'sd40296;
    localparam logic signed [TermW-1:0] CoefVG = 25'sd33715;
    localparam logic signed [TermW-1:0] CoefVB = 25'sd6575;
    localparam logic signed [SumW-1:0]  ChromaBias = SumW'(128) <<< FracW;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             col_odd;
        logic             row_odd;
        logic [SlotW-1:0] slot;
        logic             frame_end;
    } t_pix_ctrl;

    function automatic logic [CfgW-1:0] eff_size(input logic [CfgW-1:0] v,
                                                 input logic [CfgW-1:0] maxv);
        logic [CfgW-1:0] t;
        t = v;
        if (t < SizeMin) begin
            t = SizeMin;
        end
        if (t > maxv) begin
            t = maxv;
        end
        return {t[CfgW-1:1], 1'b0};
    endfunction

    function automatic logic [PixW-1:0] chroma_byte(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] t;
        logic [PixW-1:0]        res;
        t = s + ChromaBias;
        if (t[SumW-1]) begin
            res = '0;
        end else if (|t[SumW-2:FracW+PixW]) begin
            res = '1;
        end else begin
            res = t[FracW+PixW-1:FracW];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/rgb_to_yuv420_converter.sv @@
// Top level of the RGB to YUV 4:2:0 converter.
// Each pixel passes the input register, the matrix register and the output register.
// Throughput: one pixel per cycle unless the master side stalls; at most one line-store read and write.
// Reset (i_rst_n low, synchronous): counters, pipeline valids and chroma left
// terms clear, frame width and height return to 2; the line store is not cleared.
`default_nettype none
module rgb_to_yuv420_converter
    import rtyc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [3*PixW-1:0] i_s_axis_tdata,  // red, green, blue
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic      [3*PixW-1:0] o_m_axis_tdata,  // luma, chroma_u, chroma_v
    output logic                   o_m_axis_tuser,  // chroma_valid
    output logic                   o_m_axis_tlast
);

    logic [CfgW-1:0]   frame_width;
    logic [CfgW-1:0]   frame_height;
    logic              s1_valid;
    logic              s1_ready;
    logic [3*PixW-1:0] s1_data;
    t_pix_ctrl         s1_ctrl;

    rtyc_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height)
    );

    rtyc_pixel_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (frame_width),
        .i_frame_height (frame_height),
        .i_valid        (i_s_axis_tvalid),
        .i_data         (i_s_axis_tdata),
        .o_ready        (o_s_axis_tready),
        .o_valid        (s1_valid),
        .o_data         (s1_data),
        .o_ctrl         (s1_ctrl),
        .i_ready        (s1_ready)
    );

    rtyc_chroma_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s1_valid),
        .i_data           (s1_data),
        .i_ctrl           (s1_ctrl),
        .o_ready          (s1_ready),
        .o_m_valid        (o_m_axis_tvalid),
        .o_m_data         (o_m_axis_tdata),
        .o_m_chroma_valid (o_m_axis_tuser),
        .o_m_frame_end    (o_m_axis_tlast),
        .i_m_ready        (i_m_axis_tready)
    );

endmodule
`default_nettype wire

@@ sv/rtyc_apb_regs.sv @@
// APB register file holding the frame width and height.
`default_nettype none
module rtyc_apb_regs
    import rtyc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [DataW-1:0] pwdata,
    output logic      [DataW-1:0] prdata,
    output logic                  pready,
    output logic      [CfgW-1:0]  o_frame_width,
    output logic      [CfgW-1:0]  o_frame_height
);

    logic [CfgW-1:0] r_width;
    logic [CfgW-1:0] r_height;
    logic            wr_en;
    t_reg_idx        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SizeMin;
            r_height <= SizeMin;
        end else if (wr_en) begin
            unique case (idx)
                REG_FRAME_WIDTH:  r_width  <= pwdata[CfgW-1:0];
                REG_FRAME_HEIGHT: r_height <= pwdata[CfgW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = DataW'(r_width);
            REG_FRAME_HEIGHT: prdata = DataW'(r_height);
            default:          prdata = '0;
        endcase
    end

    assign o_frame_width  = r_width;
    assign o_frame_height = r_height;

endmodule
`default_nettype wire

@@ sv/rtyc_pixel_front.sv @@
// Input register stage with column and row counters.
`default_nettype none
module rtyc_pixel_front
    import rtyc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CfgW-1:0]   i_frame_width,
    input  wire logic [CfgW-1:0]   i_frame_height,
    input  wire logic              i_valid,
    input  wire logic [3*PixW-1:0] i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic      [3*PixW-1:0] o_data,
    output t_pix_ctrl              o_ctrl,
    input  wire logic              i_ready
);

    logic              r_valid;
    logic [3*PixW-1:0] r_data;
    t_pix_ctrl         r_ctrl;
    logic [ColW-1:0]   r_col;
    logic [RowW-1:0]   r_row;
    logic [ColW-1:0]   n_col;
    logic [RowW-1:0]   n_row;
    logic [CfgW-1:0]   w_eff;
    logic [CfgW-1:0]   h_eff;
    logic              last_col;
    logic              last_row;
    logic              accept;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign w_eff    = eff_size(i_frame_width, WidthMax);
    assign h_eff    = eff_size(i_frame_height, HeightMax);
    assign last_col = (CfgW'(r_col) + CfgW'(1)) >= w_eff;
    assign last_row = (CfgW'(r_row) + CfgW'(1)) >= h_eff;

    always_comb begin
        n_col = r_col + ColW'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RowW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data           <= i_data;
            r_ctrl.col_odd   <= r_col[0];
            r_ctrl.row_odd   <= r_row[0];
            r_ctrl.slot      <= r_col[ColW-1:1];
            r_ctrl.frame_end <= last_col && last_row;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_ctrl  = r_ctrl;

endmodule
`default_nettype wire

@@ sv/rtyc_chroma_back.sv @@
// Color matrix, chroma line store, 2x2 averaging and output register.
`default_nettype none
module rtyc_chroma_back
    import rtyc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [3*PixW-1:0] i_data,
    input  wire t_pix_ctrl         i_ctrl,
    output logic                   o_ready,
    output logic                   o_m_valid,
    output logic      [3*PixW-1:0] o_m_data,
    output logic                   o_m_chroma_valid,
    output logic                   o_m_frame_end,
    input  wire logic              i_m_ready
);

    logic signed [PairW-1:0] mem_u [PairSlots];
    logic signed [PairW-1:0] mem_v [PairSlots];

    logic signed [TermW-1:0] rs, gs, bs;
    logic signed [TermW-1:0] yq, uq, vq;
    logic signed [PairW-1:0] pu, pv;
    logic signed [SumW-1:0]  sum_u, sum_v;
    logic                    en_out;
    logic                    adv2;
    logic                    load2;
    logic                    chroma_ok;
    logic                    mem_wr;

    logic                    r_v2;
    logic [PixW-1:0]         r_luma;
    logic signed [TermW-1:0] r_uq, r_vq;
    t_pix_ctrl               r_ctrl2;
    logic signed [PairW-1:0] r_rd_u, r_rd_v;
    logic signed [TermW-1:0] r_left_u, r_left_v;

    logic                    r_ov;
    logic [3*PixW-1:0]       r_odata;
    logic                    r_ocv;
    logic                    r_oend;

    assign rs = TermW'(i_data[PixW-1:0]);
    assign gs = TermW'(i_data[2*PixW-1:PixW]);
    assign bs = TermW'(i_data[3*PixW-1:2*PixW]);
    assign yq = CoefYR * rs + CoefYG * gs + CoefYB * bs;
    assign uq = CoefUB * bs - CoefUG * gs - CoefUR * rs;
    assign vq = CoefVR * rs - CoefVG * gs - CoefVB * bs;

    assign en_out  = !r_ov || i_m_ready;
    assign o_ready = !r_v2 || en_out;
    assign load2   = i_valid && o_ready;
    assign adv2    = r_v2 && en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_ready) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_luma  <= yq[16+PixW-1:16];
            r_uq    <= uq;
            r_vq    <= vq;
            r_ctrl2 <= i_ctrl;
            r_rd_u  <= mem_u[i_ctrl.slot];
            r_rd_v  <= mem_v[i_ctrl.slot];
        end
    end

    assign pu        = PairW'(r_left_u) + PairW'(r_uq);
    assign pv        = PairW'(r_left_v) + PairW'(r_vq);
    assign sum_u     = SumW'(r_rd_u) + SumW'(pu);
    assign sum_v     = SumW'(r_rd_v) + SumW'(pv);
    assign chroma_ok = r_ctrl2.col_odd && r_ctrl2.row_odd;
    assign mem_wr    = adv2 && r_ctrl2.col_odd && !r_ctrl2.row_odd;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_u[r_ctrl2.slot] <= pu;
            mem_v[r_ctrl2.slot] <= pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_u <= '0;
            r_left_v <= '0;
        end else if (adv2 && !r_ctrl2.col_odd) begin
            r_left_u <= r_uq;
            r_left_v <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_odata <= {chroma_ok ? chroma_byte(sum_v) : PixW'(0),
                        chroma_ok ? chroma_byte(sum_u) : PixW'(0),
                        r_luma};
            r_ocv   <= chroma_ok;
            r_oend  <= r_ctrl2.frame_end;
        end
    end

    assign o_m_valid        = r_ov;
    assign o_m_data         = r_odata;
    assign o_m_chroma_valid = r_ocv;
    assign o_m_frame_end    = r_oend;

endmodule
`default_nettype wire

@@ sv/rtyc_checker.sv @@
// Port-level assertions for the converter and their bind.
`default_nettype none
module rtyc_checker
    import rtyc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_s_axis_tready,
    input wire logic              o_m_axis_tvalid,
    input wire logic              i_m_axis_tready,
    input wire logic [3*PixW-1:0] o_m_axis_tdata,
    input wire logic              o_m_axis_tuser,
    input wire logic              o_m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[3*PixW-1:PixW] == '0)
        else $error("chroma bytes nonzero without chroma flag");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output is empty");

endmodule

bind rgb_to_yuv420_converter rtyc_checker u_rtyc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire
